FILE: rtl/cwdc_pkg.sv
// shared types and constants for the card whitelist door controller
`default_nettype none
package cwdc_pkg;

    localparam int MAX_ENTRIES_DEF = 4;

    localparam int ID_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int POLLS_W = 4;
    localparam int DELAY_W = 16;
    localparam int MODE_W  = 2;
    localparam int PHASE_W = 2;
    localparam int EVENT_W = 3;
    localparam int VERDICT_W = 2;
    localparam int USED_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_REMOVAL_POLLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_DELAY   = 1'd1;

    localparam logic [POLLS_W-1:0] POLLS_RESET = 4'd3;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd30;
    localparam logic [DELAY_W-1:0] GRANT_CLOSE = 16'd30;

    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEL    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic [PHASE_W-1:0] PH_IDLE      = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PROCESSED = 2'd1;
    localparam logic [PHASE_W-1:0] PH_UNLOCKED  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_CLOSING   = 2'd3;

    localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_GRANTED  = 3'd1;
    localparam logic [EVENT_W-1:0] EV_LOCKED   = 3'd2;
    localparam logic [EVENT_W-1:0] EV_ADD_OK   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_ADD_FAIL = 3'd4;
    localparam logic [EVENT_W-1:0] EV_DEL_OK   = 3'd5;
    localparam logic [EVENT_W-1:0] EV_DEL_FAIL = 3'd6;
    localparam logic [EVENT_W-1:0] EV_DENIED   = 3'd7;

    localparam logic [VERDICT_W-1:0] VD_NONE = 2'd0;
    localparam logic [VERDICT_W-1:0] VD_OK   = 2'd1;
    localparam logic [VERDICT_W-1:0] VD_FAIL = 2'd2;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic rd_next;
        logic idx_inc;
        logic mark_found;
        logic shift_wr;
        logic apply;
    } t_dp_cmd;

    typedef struct packed {
        logic need_search;
        logic cnt_zero;
        logic match;
        logic last;
        logic more_shift;
        logic del_mode;
    } t_dp_sts;

endpackage
`default_nettype wire

FILE: rtl/cwdc_ctrl.sv
// sequencer for lookup, compaction and result hand-off
`default_nettype none
module cwdc_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    input  cwdc_pkg::t_dp_sts     i_sts,
    output cwdc_pkg::t_dp_cmd     o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_RD     = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_SHRD   = 3'd4;
    localparam logic [2:0] S_SHWR   = 3'd5;
    localparam logic [2:0] S_APPLY  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.need_search && !i_sts.cnt_zero) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_CMP;
            end
            S_CMP: begin
                if (i_sts.match) begin
                    o_cmd.mark_found = 1'b1;
                    n_state = i_sts.del_mode ? S_SHRD : S_APPLY;
                end else if (i_sts.last) begin
                    n_state = S_APPLY;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_SHRD: begin
                if (i_sts.more_shift) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_SHWR;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_SHWR: begin
                o_cmd.shift_wr = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = S_SHRD;
            end
            S_APPLY: begin
                if (out_free) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.apply) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/cwdc_dp.sv
// whitelist memory, door state registers and result register
`default_nettype none
module cwdc_dp #(
    parameter int MAX_ENTRIES = cwdc_pkg::MAX_ENTRIES_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_valid,
    input  wire  [cwdc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [cwdc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire                                i_cmd,
    input  wire  [cwdc_pkg::MODE_W-1:0]        i_new_mode,
    input  wire                                i_card_present,
    input  wire                                i_id_read_ok,
    input  wire  [cwdc_pkg::ID_W-1:0]          i_card_id,
    input  cwdc_pkg::t_dp_cmd                  i_ctl,
    output cwdc_pkg::t_dp_sts                  o_sts,
    output logic [cwdc_pkg::VERDICT_W-1:0]     o_verdict,
    output logic [cwdc_pkg::EVENT_W-1:0]       o_event_code,
    output logic                               o_lock_open,
    output logic [cwdc_pkg::MODE_W-1:0]        o_mode_now,
    output logic [cwdc_pkg::USED_W-1:0]        o_entries_used,
    output logic [cwdc_pkg::ID_W-1:0]          o_last_seen_id,
    output logic                               o_last_seen_valid
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    // configuration
    logic [cwdc_pkg::POLLS_W-1:0] r_polls;
    logic [cwdc_pkg::DELAY_W-1:0] r_delay;

    // latched request
    logic                          r_cmd;
    logic [cwdc_pkg::MODE_W-1:0]   r_new_mode;
    logic                          r_present;
    logic                          r_idok;
    logic [cwdc_pkg::ID_W-1:0]     r_id;

    // door state
    logic [CNT_W-1:0]              r_count,  n_count;
    logic [cwdc_pkg::MODE_W-1:0]   r_mode,   n_mode;
    logic [cwdc_pkg::PHASE_W-1:0]  r_phase,  n_phase;
    logic [cwdc_pkg::POLLS_W-1:0]  r_miss,   n_miss;
    logic [cwdc_pkg::DELAY_W-1:0]  r_close,  n_close;
    logic                          r_lock,   n_lock;
    logic [cwdc_pkg::ID_W-1:0]     r_recent, n_recent;
    logic                          r_rvalid, n_rvalid;
    logic [cwdc_pkg::VERDICT_W-1:0] n_verdict;
    logic [cwdc_pkg::EVENT_W-1:0]   n_event;
    logic                          add_wr;

    // lookup
    logic [IDX_W-1:0]              r_idx;
    logic                          r_found;
    logic [CNT_W-1:0]              idx_p1;
    logic [cwdc_pkg::ID_W-1:0]     r_mem [MAX_ENTRIES];
    logic [cwdc_pkg::ID_W-1:0]     r_rd_data;
    logic [IDX_W-1:0]              rd_addr;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    logic [cwdc_pkg::ID_W-1:0]     wr_data;

    logic [cwdc_pkg::POLLS_W-1:0]  miss_p1;
    logic [CNT_W+2:0]              cnt_ext;

    assign idx_p1 = CNT_W'(r_idx) + 1'b1;

    assign o_sts.need_search = !r_cmd && (r_phase == cwdc_pkg::PH_IDLE) && r_present && r_idok;
    assign o_sts.cnt_zero    = (r_count == '0);
    assign o_sts.match       = (r_rd_data == r_id);
    assign o_sts.last        = (idx_p1 >= r_count);
    assign o_sts.more_shift  = (idx_p1 < r_count);
    assign o_sts.del_mode    = (r_mode == cwdc_pkg::MODE_DEL);

    assign rd_addr = i_ctl.rd_next ? idx_p1[IDX_W-1:0] : r_idx;
    assign wr_en   = i_ctl.shift_wr || (i_ctl.apply && add_wr);
    assign wr_addr = i_ctl.shift_wr ? r_idx : r_count[IDX_W-1:0];
    assign wr_data = i_ctl.shift_wr ? r_rd_data : r_id;

    assign miss_p1 = r_miss + 1'b1;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // next door state for the latched request
    always_comb begin
        n_count   = r_count;
        n_mode    = r_mode;
        n_phase   = r_phase;
        n_miss    = r_miss;
        n_close   = r_close;
        n_lock    = r_lock;
        n_recent  = r_recent;
        n_rvalid  = r_rvalid;
        n_verdict = cwdc_pkg::VD_NONE;
        n_event   = cwdc_pkg::EV_NONE;
        add_wr    = 1'b0;
        if (r_cmd) begin
            n_mode  = (r_new_mode == cwdc_pkg::MODE_UNUSED) ? cwdc_pkg::MODE_NORMAL : r_new_mode;
            n_phase = cwdc_pkg::PH_IDLE;
            n_miss  = '0;
        end else if (r_phase == cwdc_pkg::PH_UNLOCKED || r_phase == cwdc_pkg::PH_PROCESSED) begin
            if (r_present) begin
                n_miss = '0;
            end else if (miss_p1 < r_polls) begin
                n_miss = miss_p1;
            end else begin
                n_miss = '0;
                if (r_phase == cwdc_pkg::PH_UNLOCKED) begin
                    n_phase = cwdc_pkg::PH_CLOSING;
                    n_close = r_delay;
                end else begin
                    n_phase = cwdc_pkg::PH_IDLE;
                end
            end
        end else if (r_phase == cwdc_pkg::PH_CLOSING) begin
            if (r_close != '0) begin
                n_close = r_close - 1'b1;
            end else begin
                n_lock  = 1'b0;
                n_event = cwdc_pkg::EV_LOCKED;
                n_phase = cwdc_pkg::PH_IDLE;
            end
        end else if (r_present && r_idok) begin
            n_recent = r_id;
            n_rvalid = 1'b1;
            if (r_mode == cwdc_pkg::MODE_ADD) begin
                if (r_count >= CNT_MAX || r_found) begin
                    n_verdict = cwdc_pkg::VD_FAIL;
                    n_event   = cwdc_pkg::EV_ADD_FAIL;
                end else begin
                    add_wr    = 1'b1;
                    n_count   = r_count + 1'b1;
                    n_verdict = cwdc_pkg::VD_OK;
                    n_event   = cwdc_pkg::EV_ADD_OK;
                end
                n_phase = cwdc_pkg::PH_PROCESSED;
                n_mode  = cwdc_pkg::MODE_NORMAL;
            end else if (r_mode == cwdc_pkg::MODE_DEL) begin
                if (!r_found) begin
                    n_verdict = cwdc_pkg::VD_FAIL;
                    n_event   = cwdc_pkg::EV_DEL_FAIL;
                end else begin
                    n_count   = r_count - 1'b1;
                    n_verdict = cwdc_pkg::VD_OK;
                    n_event   = cwdc_pkg::EV_DEL_OK;
                end
                n_phase = cwdc_pkg::PH_PROCESSED;
                n_mode  = cwdc_pkg::MODE_NORMAL;
            end else if (r_found) begin
                n_lock    = 1'b1;
                n_close   = cwdc_pkg::GRANT_CLOSE;
                n_phase   = cwdc_pkg::PH_UNLOCKED;
                n_miss    = '0;
                n_verdict = cwdc_pkg::VD_OK;
                n_event   = cwdc_pkg::EV_GRANTED;
            end else begin
                n_verdict = cwdc_pkg::VD_FAIL;
                n_event   = cwdc_pkg::EV_DENIED;
                n_phase   = cwdc_pkg::PH_PROCESSED;
            end
        end
    end

    assign cnt_ext = {3'b000, n_count};

    // latched request and result payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd      <= i_cmd;
            r_new_mode <= i_new_mode;
            r_present  <= i_card_present;
            r_idok     <= i_id_read_ok;
            r_id       <= i_card_id;
        end
        if (i_ctl.apply) begin
            o_verdict         <= n_verdict;
            o_event_code      <= n_event;
            o_lock_open       <= n_lock;
            o_mode_now        <= n_mode;
            o_entries_used    <= cnt_ext[cwdc_pkg::USED_W-1:0];
            o_last_seen_id    <= n_recent;
            o_last_seen_valid <= n_rvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_found <= 1'b0;
        end else if (i_ctl.load) begin
            r_idx   <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_ctl.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_ctl.mark_found) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polls  <= cwdc_pkg::POLLS_RESET;
            r_delay  <= cwdc_pkg::DELAY_RESET;
            r_count  <= '0;
            r_mode   <= cwdc_pkg::MODE_NORMAL;
            r_phase  <= cwdc_pkg::PH_IDLE;
            r_miss   <= '0;
            r_close  <= '0;
            r_lock   <= 1'b0;
            r_recent <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_index == cwdc_pkg::CFG_REMOVAL_POLLS) begin
                r_polls <= i_cfg_data[cwdc_pkg::POLLS_W-1:0];
            end
            if (i_cfg_valid && i_cfg_index == cwdc_pkg::CFG_CLOSE_DELAY) begin
                r_delay <= i_cfg_data[cwdc_pkg::DELAY_W-1:0];
            end
            if (i_ctl.apply) begin
                r_count  <= n_count;
                r_mode   <= n_mode;
                r_phase  <= n_phase;
                r_miss   <= n_miss;
                r_close  <= n_close;
                r_lock   <= n_lock;
                r_recent <= n_recent;
                r_rvalid <= n_rvalid;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/card_whitelist_door_controller_unit.sv
// top level of the card whitelist door controller
// sequence: a request is latched, decided and applied; a lookup first reads and compares
// the whitelist entries in turn, and a delete then moves each later entry down one slot
// throughput: one request at a time; the next is taken the cycle after its result is
// registered, while that result may still wait on the output
// reset: synchronous active low; clears mode, phase, counters, lock and last id,
// loads removal polls 3 and close delay 30; whitelist contents are not cleared
`default_nettype none
module card_whitelist_door_controller_unit #(
    parameter int MAX_ENTRIES = cwdc_pkg::MAX_ENTRIES_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [cwdc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [cwdc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire                                i_cmd,
    input  wire  [cwdc_pkg::MODE_W-1:0]        i_new_mode,
    input  wire                                i_card_present,
    input  wire                                i_id_read_ok,
    input  wire  [cwdc_pkg::ID_W-1:0]          i_card_id,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [cwdc_pkg::VERDICT_W-1:0]     o_verdict,
    output logic [cwdc_pkg::EVENT_W-1:0]       o_event_code,
    output logic                               o_lock_open,
    output logic [cwdc_pkg::MODE_W-1:0]        o_mode_now,
    output logic [cwdc_pkg::USED_W-1:0]        o_entries_used,
    output logic [cwdc_pkg::ID_W-1:0]          o_last_seen_id,
    output logic                               o_last_seen_valid
);

    cwdc_pkg::t_dp_cmd ctl;
    cwdc_pkg::t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    cwdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (ctl)
    );

    cwdc_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (i_cmd),
        .i_new_mode        (i_new_mode),
        .i_card_present    (i_card_present),
        .i_id_read_ok      (i_id_read_ok),
        .i_card_id         (i_card_id),
        .i_ctl             (ctl),
        .o_sts             (sts),
        .o_verdict         (o_verdict),
        .o_event_code      (o_event_code),
        .o_lock_open       (o_lock_open),
        .o_mode_now        (o_mode_now),
        .o_entries_used    (o_entries_used),
        .o_last_seen_id    (o_last_seen_id),
        .o_last_seen_valid (o_last_seen_valid)
    );

endmodule
`default_nettype wire

FILE: dv/card_whitelist_door_controller_unit_tb.sv
// self-checking testbench for the card whitelist door controller with a built-in door predictor
`default_nettype none
module card_whitelist_door_controller_unit_tb;
    import cwdc_pkg::*;

    localparam int LIST_DEPTH = MAX_ENTRIES_DEF;
    localparam int LIST_IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int STALL_LIMIT = 3000;
    localparam int ITEMS_PER_SETTING = 250;
    localparam int SETTING_COUNT = 6;
    localparam logic [SETTING_COUNT-1:0][POLLS_W-1:0] POLLS_PLAN =
        {4'd3, 4'd2, 4'd7, 4'd0, 4'd15, 4'd1};
    localparam logic [SETTING_COUNT-1:0][DELAY_W-1:0] DELAY_PLAN =
        {16'd30, 16'd17, 16'd1000, 16'd2, 16'hFFFF, 16'd0};

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [EVENT_W-1:0]   event_code;
        logic                 lock_open;
        logic [MODE_W-1:0]    mode_now;
        logic [USED_W-1:0]    entries_used;
        logic [ID_W-1:0]      last_seen_id;
        logic                 last_seen_valid;
    } door_result_t;

    class door_scoreboard;
        door_result_t     expected_q[$];
        logic [ID_W-1:0]  whitelist [LIST_DEPTH];
        logic [USED_W-1:0] used;
        logic [MODE_W-1:0] mode;
        logic [PHASE_W-1:0] door_phase;
        logic [POLLS_W-1:0] miss_count;
        logic [DELAY_W-1:0] close_count;
        logic             lock_open;
        logic [ID_W-1:0]  recent_id;
        logic             recent_valid;
        logic [POLLS_W-1:0] removal_polls;
        logic [DELAY_W-1:0] close_delay;
        int               mismatches;
        int               checked;
        int               event_hits [8];

        function new();
            foreach (whitelist[k]) whitelist[k] = '0;
            foreach (event_hits[k]) event_hits[k] = 0;
            used = '0;
            mode = MODE_NORMAL;
            door_phase = PH_IDLE;
            miss_count = '0;
            close_count = '0;
            lock_open = 1'b0;
            recent_id = '0;
            recent_valid = 1'b0;
            removal_polls = POLLS_RESET;
            close_delay = DELAY_RESET;
            mismatches = 0;
            checked = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_REMOVAL_POLLS) begin
                removal_polls = data[POLLS_W-1:0];
            end else if (idx == CFG_CLOSE_DELAY) begin
                close_delay = data[DELAY_W-1:0];
            end
        endfunction

        // a present card restarts the empty-poll count
        function bit card_removed(logic present);
            if (present) begin
                miss_count = '0;
                return 1'b0;
            end
            miss_count = miss_count + 1'b1;
            if (miss_count < removal_polls) return 1'b0;
            miss_count = '0;
            return 1'b1;
        endfunction

        function int find_id(logic [ID_W-1:0] id);
            for (int k = 0; k < int'(used); k++) begin
                if (whitelist[k] == id) return k;
            end
            return LIST_DEPTH;
        endfunction

        function void note_request(logic cmd, logic [MODE_W-1:0] nm, logic present, logic idok,
                                   logic [ID_W-1:0] id);
            door_result_t       exp_r;
            int                 at;
            logic [VERDICT_W-1:0] verdict;
            logic [EVENT_W-1:0] ev;
            verdict = VD_NONE;
            ev = EV_NONE;
            if (cmd) begin
                mode = (nm == MODE_UNUSED) ? MODE_NORMAL : nm;
                door_phase = PH_IDLE;
                miss_count = '0;
            end else begin
                case (door_phase)
                    PH_UNLOCKED: begin
                        if (card_removed(present)) begin
                            door_phase = PH_CLOSING;
                            close_count = close_delay;
                        end
                    end
                    PH_CLOSING: begin
                        if (close_count != '0) begin
                            close_count = close_count - 1'b1;
                        end else begin
                            lock_open = 1'b0;
                            ev = EV_LOCKED;
                            door_phase = PH_IDLE;
                        end
                    end
                    PH_PROCESSED: begin
                        if (card_removed(present)) door_phase = PH_IDLE;
                    end
                    default: begin
                        if (present && idok) begin
                            recent_id = id;
                            recent_valid = 1'b1;
                            at = find_id(id);
                            if (mode == MODE_ADD) begin
                                if (int'(used) >= LIST_DEPTH || at != LIST_DEPTH) begin
                                    verdict = VD_FAIL;
                                    ev = EV_ADD_FAIL;
                                end else begin
                                    whitelist[used[LIST_IDX_W-1:0]] = id;
                                    used = used + 1'b1;
                                    verdict = VD_OK;
                                    ev = EV_ADD_OK;
                                end
                                door_phase = PH_PROCESSED;
                                mode = MODE_NORMAL;
                            end else if (mode == MODE_DEL) begin
                                if (at == LIST_DEPTH) begin
                                    verdict = VD_FAIL;
                                    ev = EV_DEL_FAIL;
                                end else begin
                                    // close the gap left by the removed entry
                                    for (int k = at; k + 1 < int'(used); k++) begin
                                        whitelist[k] = whitelist[k+1];
                                    end
                                    used = used - 1'b1;
                                    verdict = VD_OK;
                                    ev = EV_DEL_OK;
                                end
                                door_phase = PH_PROCESSED;
                                mode = MODE_NORMAL;
                            end else if (at != LIST_DEPTH) begin
                                lock_open = 1'b1;
                                close_count = GRANT_CLOSE;
                                door_phase = PH_UNLOCKED;
                                miss_count = '0;
                                verdict = VD_OK;
                                ev = EV_GRANTED;
                            end else begin
                                verdict = VD_FAIL;
                                ev = EV_DENIED;
                                door_phase = PH_PROCESSED;
                            end
                        end
                    end
                endcase
            end
            exp_r = '{verdict, ev, lock_open, mode, used, recent_id, recent_valid};
            expected_q.push_back(exp_r);
            event_hits[ev]++;
        endfunction

        function void compare_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(door_result_t got);
            door_result_t want;
            if (expected_q.size() == 0) begin
                $error("result arrived with no request outstanding");
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("verdict", want.verdict, got.verdict);
            compare_field("event_code", want.event_code, got.event_code);
            compare_field("lock_open", want.lock_open, got.lock_open);
            compare_field("mode_now", want.mode_now, got.mode_now);
            compare_field("entries_used", want.entries_used, got.entries_used);
            compare_field("last_seen_id", want.last_seen_id, got.last_seen_id);
            compare_field("last_seen_valid", want.last_seen_valid, got.last_seen_valid);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_cmd = 1'b0;
    logic [MODE_W-1:0]     i_new_mode = '0;
    logic                  i_card_present = 1'b0;
    logic                  i_id_read_ok = 1'b0;
    logic [ID_W-1:0]       i_card_id = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [VERDICT_W-1:0]  o_verdict;
    logic [EVENT_W-1:0]    o_event_code;
    logic                  o_lock_open;
    logic [MODE_W-1:0]     o_mode_now;
    logic [USED_W-1:0]     o_entries_used;
    logic [ID_W-1:0]       o_last_seen_id;
    logic                  o_last_seen_valid;

    door_scoreboard        sb;
    int                    tx_idle_pct = 10;
    int                    rx_idle_pct = 74;
    int                    sent_count = 0;
    int                    settings_done = 1;
    int                    stall_cycles = 0;
    logic [POLLS_W-1:0]    cur_polls = POLLS_RESET;
    logic [DELAY_W-1:0]    cur_delay = DELAY_RESET;
    logic [ID_W-1:0]       id_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001,
                                           32'h7FFF_FFFE, 32'hC3A5_5A3C, 32'h0001_0000};

    card_whitelist_door_controller_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_new_mode        (i_new_mode),
        .i_card_present    (i_card_present),
        .i_id_read_ok      (i_id_read_ok),
        .i_card_id         (i_card_id),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_verdict         (o_verdict),
        .o_event_code      (o_event_code),
        .o_lock_open       (o_lock_open),
        .o_mode_now        (o_mode_now),
        .o_entries_used    (o_entries_used),
        .o_last_seen_id    (o_last_seen_id),
        .o_last_seen_valid (o_last_seen_valid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) begin
                sb.note_request(i_cmd, i_new_mode, i_card_present, i_id_read_ok, i_card_id);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_result('{o_verdict, o_event_code, o_lock_open, o_mode_now,
                                  o_entries_used, o_last_seen_id, o_last_seen_valid});
            end
        end
        if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_request(logic cmd, logic [MODE_W-1:0] nm, logic present, logic idok,
                                logic [ID_W-1:0] id);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_new_mode <= nm;
        i_card_present <= present;
        i_id_read_ok <= idok;
        i_card_id <= id;
        do @(posedge i_clk); while (!o_in_ready);
        sent_count++;
    endtask

    task automatic scan(logic present, logic idok, logic [ID_W-1:0] id);
        send_request(1'b0, MODE_W'($urandom_range(0, 3)), present, idok, id);
    endtask

    task automatic set_mode(logic [MODE_W-1:0] m);
        send_request(1'b1, m, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_config(logic [POLLS_W-1:0] polls, logic [DELAY_W-1:0] delay);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);
        word[POLLS_W-1:0] = polls;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_REMOVAL_POLLS;
        i_cfg_data <= word;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_CLOSE_DELAY;
        i_cfg_data <= delay;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        settings_done++;
    endtask

    function automatic logic [MODE_W-1:0] pick_mode();
        int r;
        r = $urandom_range(99);
        if (r < 40) return MODE_ADD;
        if (r < 75) return MODE_DEL;
        if (r < 90) return MODE_NORMAL;
        return MODE_UNUSED;
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(99) < 80) return id_pool[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    // random traffic: mode changes, card visits (reads, then empty polls, then closing ticks) and raw requests
    task automatic run_random(int quota);
        int              stop_at;
        int              kind;
        int              tail;
        logic [ID_W-1:0] id;
        stop_at = sent_count + quota;
        while (sent_count < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 15) begin
                set_mode(pick_mode());
            end else if (kind < 80) begin
                id = pick_id();
                repeat ($urandom_range(1, 3)) scan(1'b1, $urandom_range(99) < 85, id);
                repeat ($urandom_range(0, int'(cur_polls) + 2)) begin
                    scan(1'b0, 1'($urandom_range(0, 1)), $urandom);
                end
                tail = (cur_delay <= 40) ? $urandom_range(0, int'(cur_delay) + 3)
                                         : $urandom_range(0, 20);
                repeat (tail) scan(1'b0, 1'($urandom_range(0, 1)), $urandom);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_request(1'($urandom_range(0, 1)), MODE_W'($urandom_range(0, 3)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 $urandom);
                end
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no card, partial reads
        scan(1'b0, 1'b0, 32'h0000_0000);
        scan(1'b1, 1'b0, 32'hA5A5_A5A5);
        scan(1'b0, 1'b1, 32'h5A5A_5A5A);
        // unknown card denied, then wait for removal
        scan(1'b1, 1'b1, 32'h1234_5678);
        scan(1'b1, 1'b1, 32'h1234_5678);
        repeat (3) scan(1'b0, 1'b0, 32'h0000_0000);
        // fill the list, duplicate and full cases
        set_mode(MODE_ADD);
        scan(1'b1, 1'b1, 32'hFFFF_FFFF);
        set_mode(MODE_ADD);
        scan(1'b1, 1'b1, 32'hFFFF_FFFF);
        set_mode(MODE_ADD);
        scan(1'b1, 1'b1, 32'h0000_0000);
        set_mode(MODE_ADD);
        scan(1'b1, 1'b1, id_pool[2]);
        set_mode(MODE_ADD);
        scan(1'b1, 1'b1, id_pool[3]);
        set_mode(MODE_ADD);
        scan(1'b1, 1'b1, id_pool[4]);
        // delete unknown, then delete from the middle
        set_mode(MODE_DEL);
        scan(1'b1, 1'b1, 32'h1234_5678);
        set_mode(MODE_DEL);
        scan(1'b1, 1'b1, 32'h0000_0000);
        // unused mode code, grant, mode change with the lock open
        set_mode(MODE_UNUSED);
        scan(1'b1, 1'b1, 32'hFFFF_FFFF);
        set_mode(MODE_NORMAL);

        for (int s = 0; s < SETTING_COUNT; s++) begin
            drain();
            tx_idle_pct = (s < 2) ? 10 : (s < 4) ? 74 : 0;
            rx_idle_pct = (s < 2) ? 74 : (s < 4) ? 10 : 0;
            cur_polls = POLLS_PLAN[s];
            cur_delay = DELAY_PLAN[s];
            program_config(cur_polls, cur_delay);
            run_random(ITEMS_PER_SETTING);
        end
        drain();
        repeat (30) @(posedge i_clk);

        $display("run covered %0d requests under %0d register settings, %0d results checked",
                 sent_count, settings_done, sb.checked);
        $display("events: granted %0d locked %0d add ok %0d add fail %0d",
                 sb.event_hits[EV_GRANTED], sb.event_hits[EV_LOCKED],
                 sb.event_hits[EV_ADD_OK], sb.event_hits[EV_ADD_FAIL]);
        $display("        del ok %0d del fail %0d denied %0d",
                 sb.event_hits[EV_DEL_OK], sb.event_hits[EV_DEL_FAIL],
                 sb.event_hits[EV_DENIED]);
        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
rtl/cwdc_pkg.sv
rtl/cwdc_ctrl.sv
rtl/cwdc_dp.sv
rtl/card_whitelist_door_controller_unit.sv
dv/card_whitelist_door_controller_unit_tb.sv
